// ===== rtl/core/mandelbrot_escape_time_pixel_unit_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the mandelbrot escape-time pixel unit
// clocked checks with an active-low reset guard
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MET_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// condition must never be seen
`define MET_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/core/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg
// shared types, register codes, reset values and saturation helpers
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int WORD_W      = 32;
    localparam int ITER_W      = 14;
    localparam int RADIUS_W    = 31;
    localparam int STEP_W      = 31;
    localparam int PAL_W       = 6;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ITER_W-1:0] LIMIT_MIN = 14'd1;
    localparam logic [ITER_W-1:0] LIMIT_MAX = 14'd10000;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_ITER  = 3'd0,
        REG_RADIUS_SQ = 3'd1,
        REG_RE_LEFT   = 3'd2,
        REG_IM_TOP    = 3'd3,
        REG_RE_STEP   = 3'd4,
        REG_IM_STEP   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic        [ITER_W-1:0]   iter_limit;
        logic        [RADIUS_W-1:0] escape_radius_sq;
        logic signed [WORD_W-1:0]   re_left;
        logic signed [WORD_W-1:0]   im_top;
        logic        [STEP_W-1:0]   re_step;
        logic        [STEP_W-1:0]   im_step;
    } t_cfg;

    // limit 20, radius squared 4.0, left -2.0, top 1.0, steps 3/1024 and 2/768
    localparam t_cfg CFG_RESET = '{
        iter_limit:       14'd20,
        escape_radius_sq: 31'd1073741824,
        re_left:          -32'sd536870912,
        im_top:           32'sd268435456,
        re_step:          31'd786432,
        im_step:          31'd699051
    };

    // clip a 64-bit signed value to the 32-bit signed range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
        logic fits;
        fits = (v[63:WORD_W-1] == {(64-WORD_W+1){v[WORD_W-1]}});
        if (fits) begin
            return v[WORD_W-1:0];
        end
        return v[63] ? WORD_MIN : WORD_MAX;
    endfunction

    // clip a 33-bit signed sum to the 32-bit signed range
    function automatic logic signed [WORD_W-1:0] sat_sum(input logic signed [WORD_W:0] v);
        if (v[WORD_W] == v[WORD_W-1]) begin
            return v[WORD_W-1:0];
        end
        return v[WORD_W] ? WORD_MIN : WORD_MAX;
    endfunction

endpackage

// ===== rtl/core/met_front.sv =====
// ----------------------------------------------------------------------------
// met_front
// takes pixel items and maps each pixel onto its point c in the plane
// ----------------------------------------------------------------------------
module met_front import met_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [COORD_BITS-1:0]         i_px,
    input  logic [COORD_BITS-1:0]         i_py,
    input  t_cfg                          i_cfg,
    input  logic                          i_q_full,
    output logic                          o_busy,
    output logic                          o_push,
    output logic [2*COORD_BITS+2*WORD_W-1:0] o_point
);

    localparam int PROD_W = COORD_BITS + STEP_W;
    localparam int SUM_W  = PROD_W + 2;

    logic                    r_s1_valid;
    logic [COORD_BITS-1:0]   r_px;
    logic [COORD_BITS-1:0]   r_py;
    logic [PROD_W-1:0]       r_prod_re;
    logic [PROD_W-1:0]       r_prod_im;

    logic                    accept;
    logic signed [SUM_W-1:0] sum_re;
    logic signed [SUM_W-1:0] sum_im;
    logic signed [WORD_W-1:0] c_re;
    logic signed [WORD_W-1:0] c_im;

    assign o_busy = r_s1_valid && i_q_full;
    assign o_push = r_s1_valid && !i_q_full;
    assign accept = i_start && !o_busy;

    always_comb begin
        sum_re = {{(SUM_W-WORD_W){i_cfg.re_left[WORD_W-1]}}, i_cfg.re_left}
               + {2'b00, r_prod_re};
        sum_im = {{(SUM_W-WORD_W){i_cfg.im_top[WORD_W-1]}}, i_cfg.im_top}
               - {2'b00, r_prod_im};
        if (sum_re[SUM_W-1:WORD_W-1] == {(SUM_W-WORD_W+1){sum_re[WORD_W-1]}}) begin
            c_re = sum_re[WORD_W-1:0];
        end else begin
            c_re = sum_re[SUM_W-1] ? WORD_MIN : WORD_MAX;
        end
        if (sum_im[SUM_W-1:WORD_W-1] == {(SUM_W-WORD_W+1){sum_im[WORD_W-1]}}) begin
            c_im = sum_im[WORD_W-1:0];
        end else begin
            c_im = sum_im[SUM_W-1] ? WORD_MIN : WORD_MAX;
        end
    end

    assign o_point = {r_px, r_py, c_re, c_im};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px      <= i_px;
            r_py      <= i_py;
            r_prod_re <= PROD_W'(i_px) * PROD_W'(i_cfg.re_step);
            r_prod_im <= PROD_W'(i_py) * PROD_W'(i_cfg.im_step);
        end
    end

endmodule

// ===== rtl/core/met_queue.sv =====
// ----------------------------------------------------------------------------
// met_queue
// short first-in first-out queue between the mapping front and the iterator
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_unit_assert.svh"

module met_queue import met_pkg::*; #(
    parameter int WIDTH = 88
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    `MET_ASSERT_NEVER(a_queue_no_overflow, i_clk, i_rst_n,
        i_push && o_full, "push into full queue")
    `MET_ASSERT_NEVER(a_queue_no_underflow, i_clk, i_rst_n,
        i_pop && o_empty, "pop from empty queue")

endmodule

// ===== rtl/core/met_iter.sv =====
// ----------------------------------------------------------------------------
// met_iter
// runs z = z^2 + c for one point at a time and issues the escape result
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_unit_assert.svh"

module met_iter import met_pkg::*; #(
    parameter int FRAC_BITS    = 28,
    parameter int COORD_BITS   = 12,
    parameter int PALETTE_SIZE = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cfg                              i_cfg,
    input  logic                              i_empty,
    input  logic [2*COORD_BITS+2*WORD_W-1:0]  i_data,
    output logic                              o_pop,
    output logic                              o_done,
    output logic [COORD_BITS-1:0]             o_px_out,
    output logic [COORD_BITS-1:0]             o_py_out,
    output logic                              o_in_set,
    output logic [ITER_W-1:0]                 o_iterations,
    output logic [PAL_W-1:0]                  o_palette_index
);

    localparam int DW     = 2*COORD_BITS + 2*WORD_W;
    localparam int PAL_CW = $clog2(PALETTE_SIZE);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_STEP
    } t_state;

    t_state                    r_state;
    logic                      r_done;
    logic [COORD_BITS-1:0]     r_px;
    logic [COORD_BITS-1:0]     r_py;
    logic signed [WORD_W-1:0]  r_c_re;
    logic signed [WORD_W-1:0]  r_c_im;
    logic signed [WORD_W-1:0]  r_zr;
    logic signed [WORD_W-1:0]  r_zi;
    logic [WORD_W-2:0]         r_sr;
    logic [WORD_W-2:0]         r_si;
    logic                      r_big_r;
    logic                      r_big_i;
    logic signed [WORD_W-1:0]  r_cross;
    logic [ITER_W-1:0]         r_iter;
    logic [PAL_CW-1:0]         r_pal;
    logic                      r_in_set;
    logic [ITER_W-1:0]         r_iter_out;
    logic [PAL_CW-1:0]         r_pal_out;

    logic signed [63:0]        prod_rr;
    logic signed [63:0]        prod_ii;
    logic signed [63:0]        prod_ri;
    logic signed [63:0]        sq_rr;
    logic signed [63:0]        sq_ii;
    logic signed [WORD_W-1:0]  diff;
    logic signed [WORD_W:0]    sum_re;
    logic signed [WORD_W:0]    sum_im;
    logic signed [WORD_W-1:0]  nr;
    logic signed [WORD_W-1:0]  ni;
    logic [WORD_W-1:0]         mag;
    logic                      escape;
    logic                      last;

    // product stage: three 32x32 products, scaled, clipped and registered in ST_MUL
    always_comb begin
        prod_rr = r_zr * r_zr;
        prod_ii = r_zi * r_zi;
        prod_ri = r_zr * r_zi;
        sq_rr   = prod_rr >>> FRAC_BITS;
        sq_ii   = prod_ii >>> FRAC_BITS;
    end

    // step stage: escape test on the squares, then the next z
    always_comb begin
        mag    = WORD_W'(r_sr) + WORD_W'(r_si);
        escape = r_big_r || r_big_i || (mag > WORD_W'(i_cfg.escape_radius_sq));
        last   = (r_iter == i_cfg.iter_limit - 1'b1);
        diff   = $signed({1'b0, r_sr}) - $signed({1'b0, r_si});
        sum_re = {diff[WORD_W-1], diff} + {r_c_re[WORD_W-1], r_c_re};
        sum_im = {r_cross[WORD_W-1], r_cross} + {r_c_im[WORD_W-1], r_c_im};
        nr     = sat_sum(sum_re);
        ni     = sat_sum(sum_im);
    end

    assign o_pop           = (r_state == ST_IDLE) && !i_empty;
    assign o_done          = r_done;
    assign o_px_out        = r_px;
    assign o_py_out        = r_py;
    assign o_in_set        = r_in_set;
    assign o_iterations    = r_iter_out;
    assign o_palette_index = PAL_W'(r_pal_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        // first step from z = 0 gives z = c
                        r_px    <= i_data[DW-1 -: COORD_BITS];
                        r_py    <= i_data[DW-COORD_BITS-1 -: COORD_BITS];
                        r_c_re  <= i_data[2*WORD_W-1 -: WORD_W];
                        r_c_im  <= i_data[WORD_W-1:0];
                        r_zr    <= i_data[2*WORD_W-1 -: WORD_W];
                        r_zi    <= i_data[WORD_W-1:0];
                        r_iter  <= '0;
                        r_pal   <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_big_r <= |sq_rr[63:WORD_W-1];
                    r_big_i <= |sq_ii[63:WORD_W-1];
                    r_sr    <= (|sq_rr[63:WORD_W-1]) ? '1 : sq_rr[WORD_W-2:0];
                    r_si    <= (|sq_ii[63:WORD_W-1]) ? '1 : sq_ii[WORD_W-2:0];
                    r_cross <= sat_word(prod_ri >>> (FRAC_BITS - 1));
                    r_state <= ST_STEP;
                end
                ST_STEP: begin
                    if (escape) begin
                        r_done     <= 1'b1;
                        r_in_set   <= 1'b0;
                        r_iter_out <= r_iter;
                        r_pal_out  <= r_pal;
                        r_state    <= ST_IDLE;
                    end else if (last) begin
                        // bounded point: no palette colour
                        r_done     <= 1'b1;
                        r_in_set   <= 1'b1;
                        r_iter_out <= i_cfg.iter_limit;
                        r_pal_out  <= '0;
                        r_state    <= ST_IDLE;
                    end else begin
                        r_iter  <= r_iter + 1'b1;
                        r_pal   <= (r_pal == PAL_CW'(PALETTE_SIZE - 1)) ? '0 : r_pal + 1'b1;
                        r_zr    <= nr;
                        r_zi    <= ni;
                        r_state <= ST_MUL;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `MET_ASSERT_NEXT(a_done_one_cycle, i_clk, i_rst_n,
        r_done, !r_done, "result strobe held over two cycles")
    `MET_ASSERT_IMPLY(a_iter_below_limit, i_clk, i_rst_n,
        r_state != ST_IDLE, r_iter < i_cfg.iter_limit, "iteration count passed the limit")
    `MET_ASSERT_IMPLY(a_bounded_result, i_clk, i_rst_n,
        r_done && r_in_set, (r_pal_out == '0) && (r_iter_out == i_cfg.iter_limit),
        "bounded result malformed")

endmodule

// ===== rtl/core/mandelbrot_escape_time_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_unit
// escape-time engine: one pixel in, one escape count and palette index out
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  ------------------------------------
//  pixel     in         start high, busy low    i_px, i_py
//  result    out        o_done strobe, 1 cycle  o_px_out, o_py_out, o_in_set,
//                                               o_iterations, o_palette_index
//  config    in         i_cfg_we                i_cfg_idx, i_cfg_wdata
//
//  an item passes the mapping front register and the queue before the iterator
//  takes it; each complex iteration then runs the shared multiplier stage
//  (ST_MUL) and the step stage (ST_STEP), and the result is registered onto the
//  result ports; the iterator takes a new point only after issuing a result,
//  while the front and the queue can hold further pixels in the meantime
//  synchronous active-low reset clears control state and loads the default
//  registers; busy rises only while the queue and the front stage are both full
//  results cannot be held off by the receiver
//
module mandelbrot_escape_time_pixel_unit import met_pkg::*; #(
    parameter int FRAC_BITS    = 28,
    parameter int COORD_BITS   = 12,
    parameter int PALETTE_SIZE = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel items
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_px,
    input  logic [COORD_BITS-1:0] i_py,
    // results
    output logic                  o_done,
    output logic [COORD_BITS-1:0] o_px_out,
    output logic [COORD_BITS-1:0] o_py_out,
    output logic                  o_in_set,
    output logic [ITER_W-1:0]     o_iterations,
    output logic [PAL_W-1:0]      o_palette_index,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int POINT_W = 2*COORD_BITS + 2*WORD_W;

    // configuration registers
    t_cfg              r_cfg;
    logic [ITER_W-1:0] n_max_iter;

    // front to queue to iterator
    logic               push;
    logic [POINT_W-1:0] point;
    logic               q_full;
    logic               q_empty;
    logic               pop;
    logic [POINT_W-1:0] q_point;

    // iteration limit is clamped on write, so the iterator sees 1..10000 only
    always_comb begin
        n_max_iter = i_cfg_wdata[ITER_W-1:0];
        if (n_max_iter < LIMIT_MIN) begin
            n_max_iter = LIMIT_MIN;
        end else if (n_max_iter > LIMIT_MAX) begin
            n_max_iter = LIMIT_MAX;
        end
    end

    // writes to unknown indexes fall through and are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_ITER:  r_cfg.iter_limit       <= n_max_iter;
                REG_RADIUS_SQ: r_cfg.escape_radius_sq <= i_cfg_wdata[RADIUS_W-1:0];
                REG_RE_LEFT:   r_cfg.re_left          <= signed'(i_cfg_wdata[WORD_W-1:0]);
                REG_IM_TOP:    r_cfg.im_top           <= signed'(i_cfg_wdata[WORD_W-1:0]);
                REG_RE_STEP:   r_cfg.re_step          <= i_cfg_wdata[STEP_W-1:0];
                REG_IM_STEP:   r_cfg.im_step          <= i_cfg_wdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: accept pixel, form c = left + px*step_re, top - py*step_im
    met_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_px     (i_px),
        .i_py     (i_py),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_busy   (busy),
        .o_push   (push),
        .o_point  (point)
    );

    // queue decouples the mapping front from the long-running iterator
    met_queue #(
        .WIDTH (POINT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (point),
        .i_pop   (pop),
        .o_data  (q_point),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: iterate, test escape, issue result
    met_iter #(
        .FRAC_BITS    (FRAC_BITS),
        .COORD_BITS   (COORD_BITS),
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_iter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_empty         (q_empty),
        .i_data          (q_point),
        .o_pop           (pop),
        .o_done          (o_done),
        .o_px_out        (o_px_out),
        .o_py_out        (o_py_out),
        .o_in_set        (o_in_set),
        .o_iterations    (o_iterations),
        .o_palette_index (o_palette_index)
    );

endmodule
